[src/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Word widths, counter widths and status codes shared by the sequencer and
// the multiply-reduce unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Operand word width; each operand is its low WORD_WIDTH bits, two's complement.
    localparam int WORD_WIDTH = 32;

    // Magnitude bits of a non-negative operand.
    localparam int OPW = WORD_WIDTH - 1;

    // Full product width of two magnitudes.
    localparam int PRODW = 2 * OPW;

    // Reduction step counter, able to hold PRODW itself.
    localparam int RCW = $clog2(PRODW + 1);

    // Remaining exponent bit counter, holds 0 .. OPW-1.
    localparam int ECW = $clog2(OPW);

    // Width of the result value field.
    localparam int VALW = 31;

    // Result status codes.
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_RANGE_ERR = 1'b1;

endpackage

[src/mexp_mulmod.sv]
// ----------------------------------------------------------------------------
// Modular multiply unit
// Forms a full product, then reduces it modulo m by restoring
// shift-and-subtract, one product bit per cycle.
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mexp_pkg::OPW-1:0]  i_a,
    input  logic [mexp_pkg::OPW-1:0]  i_b,
    input  logic [mexp_pkg::OPW-1:0]  i_m,
    output logic                      o_done,
    output logic [mexp_pkg::OPW-1:0]  o_rem
);
    import mexp_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE = 2'b01,
        M_RED  = 2'b10
    } t_mm_state;

    t_mm_state          r_state, n_state;
    logic [RCW-1:0]     r_cnt, n_cnt;
    logic               r_done, n_done;
    logic [PRODW-1:0]   r_prod, n_prod;
    logic [OPW-1:0]     r_m, n_m;
    logic [OPW-1:0]     r_rem, n_rem;

    logic [OPW:0]       trial;
    logic [OPW:0]       diff;

    // One restoring step: bring in the next product bit and subtract m if it fits.
    assign trial = {r_rem, r_prod[PRODW-1]};
    assign diff  = trial - {1'b0, r_m};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_prod  = r_prod;
        n_m     = r_m;
        n_rem   = r_rem;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_prod  = PRODW'(i_a) * PRODW'(i_b);
                    n_m     = i_m;
                    n_rem   = '0;
                    n_cnt   = RCW'(PRODW);
                    n_state = M_RED;
                end
            end
            M_RED: begin
                if (trial >= {1'b0, r_m}) begin
                    n_rem = diff[OPW-1:0];
                end else begin
                    n_rem = trial[OPW-1:0];
                end
                n_prod = r_prod << 1;
                n_cnt  = r_cnt - RCW'(1);
                if (r_cnt == RCW'(1)) begin
                    n_done  = 1'b1;
                    n_state = M_IDLE;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_m    <= n_m;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[src/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation
// Left-to-right square-and-multiply of base to the exponent modulo modulus,
// with operand range checks and the trivial cases decided at once.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                      Payload
//  item in   input      i_start high, o_busy low       i_base, i_exponent, i_modulus
//  result    output     o_done for one cycle           o_value, o_status
//
//  Each modular multiply is launched, forms its product, then runs the
//  bit-serial reduction in the shared multiply-reduce unit. An item costs an
//  exponent scan, one seeding reduction, and one square per exponent bit
//  below the leading one plus one multiply per set bit among them. Errors,
//  a zero base and a zero exponent give their result in the cycle after the
//  item is taken. Reset is synchronous and active low. Results cannot be
//  held off by the receiver.
// ----------------------------------------------------------------------------
module modular_exponentiation (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [31:0]           i_base,
    input  logic signed [31:0]           i_exponent,
    input  logic signed [31:0]           i_modulus,
    output logic                         o_done,
    output logic [mexp_pkg::VALW-1:0]    o_value,
    output logic                         o_status
);
    import mexp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_SEED = 5'b00100,
        S_SQR  = 5'b01000,
        S_MUL  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [OPW-1:0]     r_exp, n_exp;
    logic [ECW-1:0]     r_cnt, n_cnt;
    logic [OPW-1:0]     r_b, n_b;
    logic [OPW-1:0]     r_m, n_m;
    logic [OPW-1:0]     r_opa, n_opa;
    logic [OPW-1:0]     r_opb, n_opb;
    logic               r_go, n_go;
    logic               r_done, n_done;
    logic [VALW-1:0]    r_value, n_value;
    logic               r_status, n_status;

    logic               mm_done;
    logic [OPW-1:0]     mm_rem;

    logic [OPW-1:0]     b_op, e_op, m_op;
    logic               op_err;

    // Operand decode: low word bits, sign checks and range checks.
    assign b_op   = i_base[OPW-1:0];
    assign e_op   = i_exponent[OPW-1:0];
    assign m_op   = i_modulus[OPW-1:0];
    assign op_err = i_base[WORD_WIDTH-1] | i_exponent[WORD_WIDTH-1]
                  | i_modulus[WORD_WIDTH-1] | (m_op[OPW-1:1] == '0)
                  | ((b_op == '0) & (e_op == '0));

    // Shared multiply-reduce unit.
    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .i_m     (r_m),
        .o_done  (mm_done),
        .o_rem   (mm_rem)
    );

    // Sequencer over the exponent bits.
    always_comb begin
        n_state  = r_state;
        n_exp    = r_exp;
        n_cnt    = r_cnt;
        n_b      = r_b;
        n_m      = r_m;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_go     = 1'b0;
        n_done   = 1'b0;
        n_value  = r_value;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_b = b_op;
                    n_m = m_op;
                    if (op_err) begin
                        n_done   = 1'b1;
                        n_value  = '0;
                        n_status = ST_RANGE_ERR;
                    end else if (b_op == '0) begin
                        n_done   = 1'b1;
                        n_value  = '0;
                        n_status = ST_OK;
                    end else if (e_op == '0) begin
                        n_done   = 1'b1;
                        n_value  = VALW'(1);
                        n_status = ST_OK;
                    end else begin
                        n_exp   = e_op;
                        n_cnt   = ECW'(OPW - 1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Shift until the leading one sits in the top bit.
                if (!r_exp[OPW-1] && (r_cnt != '0)) begin
                    n_exp = r_exp << 1;
                    n_cnt = r_cnt - ECW'(1);
                end else begin
                    n_go    = 1'b1;
                    n_opa   = r_b;
                    n_opb   = OPW'(1);
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                if (mm_done) begin
                    if (r_cnt == '0) begin
                        n_done   = 1'b1;
                        n_value  = VALW'(mm_rem);
                        n_status = ST_OK;
                        n_state  = S_IDLE;
                    end else begin
                        n_go    = 1'b1;
                        n_opa   = mm_rem;
                        n_opb   = mm_rem;
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mm_done) begin
                    if (r_exp[OPW-2]) begin
                        n_go    = 1'b1;
                        n_opa   = mm_rem;
                        n_opb   = r_b;
                        n_state = S_MUL;
                    end else begin
                        n_exp = r_exp << 1;
                        n_cnt = r_cnt - ECW'(1);
                        if (r_cnt == ECW'(1)) begin
                            n_done   = 1'b1;
                            n_value  = VALW'(mm_rem);
                            n_status = ST_OK;
                            n_state  = S_IDLE;
                        end else begin
                            n_go    = 1'b1;
                            n_opa   = mm_rem;
                            n_opb   = mm_rem;
                            n_state = S_SQR;
                        end
                    end
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    n_exp = r_exp << 1;
                    n_cnt = r_cnt - ECW'(1);
                    if (r_cnt == ECW'(1)) begin
                        n_done   = 1'b1;
                        n_value  = VALW'(mm_rem);
                        n_status = ST_OK;
                        n_state  = S_IDLE;
                    end else begin
                        n_go    = 1'b1;
                        n_opa   = mm_rem;
                        n_opb   = mm_rem;
                        n_state = S_SQR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // Operand and result registers.
    always_ff @(posedge i_clk) begin
        r_exp    <= n_exp;
        r_b      <= n_b;
        r_m      <= n_m;
        r_opa    <= n_opa;
        r_opb    <= n_opb;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_status = r_status;

    // An error result always carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_RANGE_ERR)) |-> (o_value == '0))
        else $error("error result with nonzero value");

    // A valid result is reduced below the modulus of its item.
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_OK)) |-> (o_value < VALW'(r_m)))
        else $error("result not reduced below modulus");

    // The multiply unit finishes only while the sequencer waits for it.
    a_mm_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> ((r_state == S_SEED) || (r_state == S_SQR) || (r_state == S_MUL)))
        else $error("multiply unit done outside a wait state");

    // The block turns busy only after an item has been taken.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && !$past(o_busy)) |-> $past(i_start))
        else $error("busy without an accepted item");

endmodule
